>>> hw/rtl/fmr_pkg.sv
// ----------------------------------------------------------------------------
// fmr_pkg
// Opcodes, format constants and types shared by the float min/max/round unit.
// ----------------------------------------------------------------------------
`default_nettype none
package fmr_pkg;

  typedef enum logic [3:0] {
    OP_MIN      = 4'd0,
    OP_MAX      = 4'd1,
    OP_COPYSIGN = 4'd2,
    OP_ABS      = 4'd3,
    OP_NEG      = 4'd4,
    OP_CEIL     = 4'd5,
    OP_FLOOR    = 4'd6,
    OP_TRUNC    = 4'd7,
    OP_NEAREST  = 4'd8
  } op_e;

  localparam logic [63:0] Sign32 = 64'h0000_0000_8000_0000;
  localparam logic [63:0] Sign64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] Nan32  = 64'h0000_0000_7FC0_0000;
  localparam logic [63:0] Nan64  = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] One32  = 64'h0000_0000_3F80_0000;
  localparam logic [63:0] One64  = 64'h3FF0_0000_0000_0000;

  typedef struct packed {
    logic [3:0]  opcode;
    logic        is_double;
    logic [63:0] a;
    logic [63:0] b;
  } item_t;

endpackage
`default_nettype wire

>>> hw/rtl/fmr_datapath.sv
// ----------------------------------------------------------------------------
// fmr_datapath
// Combinational min/max, sign operations and integral rounding for one item.
// ----------------------------------------------------------------------------
`default_nettype none
module fmr_datapath (
  input  fmr_pkg::item_t item_i,
  output logic [63:0]    result_o
);
  import fmr_pkg::*;

  logic [63:0] a, b, sgn, wmask, cnan, one, half, unit, mask, rem, base, rnd, mm, r;
  logic [10:0] e, expmax, bias;
  logic [5:0]  mant;
  logic        dbl, a_nan, b_nan, a_zero, b_zero, neg, a_n, b_n, up, a_lt;
  logic [63:0] ka, kb;
  logic [11:0] kdiff;
  logic        frac_nz;

  always_comb begin
    dbl    = item_i.is_double;
    wmask  = dbl ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
    sgn    = dbl ? Sign64 : Sign32;
    cnan   = dbl ? Nan64 : Nan32;
    one    = dbl ? One64 : One32;
    expmax = dbl ? 11'h7FF : 11'h0FF;
    bias   = dbl ? 11'd1023 : 11'd127;
    mant   = dbl ? 6'd52 : 6'd23;
    half   = dbl ? 64'h0008_0000_0000_0000 : 64'h0000_0000_0040_0000;
    a      = item_i.a & wmask;
    b      = item_i.b & wmask;
    e      = dbl ? a[62:52] : {3'b000, a[30:23]};
    frac_nz = dbl ? (a[51:0] != '0) : (a[22:0] != '0);
    a_nan  = (e == expmax) && frac_nz;
    b_nan  = dbl ? (b[62:52] == 11'h7FF && b[51:0] != '0)
                 : (b[30:23] == 8'hFF && b[22:0] != '0);
    a_zero = (a & ~sgn) == '0;
    b_zero = (b & ~sgn) == '0;
    a_n    = (a & sgn) != '0;
    b_n    = (b & sgn) != '0;
    neg    = a_n;
    ka     = a_n ? (~a & wmask) : (a | sgn);
    kb     = b_n ? (~b & wmask) : (b | sgn);
    a_lt   = ka < kb;

    if (a_nan || b_nan) begin
      mm = cnan;
    end else if (a_zero && b_zero) begin
      if (item_i.opcode == OP_MAX) mm = (a_n && b_n) ? sgn : '0;
      else                         mm = (a_n || b_n) ? sgn : '0;
    end else if (a == b) begin
      mm = a;
    end else if (item_i.opcode == OP_MAX) begin
      mm = (ka > kb) ? a : b;
    end else begin
      mm = a_lt ? a : b;
    end

    kdiff = {1'b0, bias} + {6'd0, mant} - {1'b0, e};
    unit  = 64'd1 << kdiff[5:0];
    mask  = unit - 64'd1;
    rem   = a & mask;
    base  = a & ~mask;
    unique case (item_i.opcode)
      OP_CEIL:  up = !neg;
      OP_FLOOR: up = neg;
      OP_TRUNC: up = 1'b0;
      default:  up = (rem > (unit >> 1)) || (rem == (unit >> 1) && (a & unit) != '0);
    endcase
    if (e == expmax) begin
      rnd = (item_i.opcode != OP_NEAREST && frac_nz) ? (a | half) : a;
    end else if ({1'b0, e} >= {1'b0, bias} + {6'd0, mant}) begin
      rnd = a;
    end else if (e < bias) begin
      if (a_zero) rnd = a;
      else begin
        unique case (item_i.opcode)
          OP_CEIL:  rnd = neg ? (a & sgn) : one;
          OP_FLOOR: rnd = neg ? (sgn | one) : '0;
          OP_TRUNC: rnd = a & sgn;
          default:  rnd = (e == bias - 11'd1 && frac_nz) ? ((a & sgn) | one) : (a & sgn);
        endcase
      end
    end else if (rem == '0) begin
      rnd = a;
    end else begin
      rnd = up ? ((base + unit) & wmask) : base;
    end

    unique case (item_i.opcode)
      OP_MIN, OP_MAX: r = mm;
      OP_COPYSIGN:    r = (a & ~sgn) | (b & sgn);
      OP_ABS:         r = a & ~sgn;
      OP_NEG:         r = a ^ sgn;
      OP_CEIL, OP_FLOOR, OP_TRUNC, OP_NEAREST: r = rnd;
      default:        r = '0;
    endcase
    result_o = r & wmask;
  end

endmodule
`default_nettype wire

>>> hw/rtl/float_minmax_round_unit.sv
// ----------------------------------------------------------------------------
// float_minmax_round_unit
// WebAssembly float min/max/copysign/abs/neg/ceil/floor/trunc/nearest unit.
// ----------------------------------------------------------------------------
// Usage:
//   Drive opcode_i, is_double_i, operand_a_i, operand_b_i with start high.
//   busy is always low, so an item is taken on every cycle start is high.
//   The item is registered, worked on by one combinational pass, and the
//   result appears on result_bits_o with done_o high for exactly one cycle,
//   once the input register and then the result register have taken it.
//   Throughput: one item per cycle; the datapath sits between the input
//   register and the result register.
//   Binary32 operands sit in the low 32 bits; results are zero-extended.
//   Reset clears the valid flags of both registers; no result is pending
//   afterwards. The receiver cannot stall: every result is shown once.
// ----------------------------------------------------------------------------
`default_nettype none
module float_minmax_round_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start,
  output logic        busy,
  input  wire  [3:0]  opcode_i,
  input  wire         is_double_i,
  input  wire  [63:0] operand_a_i,
  input  wire  [63:0] operand_b_i,
  output logic        done_o,
  output logic [63:0] result_bits_o
);
  import fmr_pkg::*;

  item_t       item_q;
  logic        vld_q, out_vld_q;
  logic [63:0] res_d, res_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      vld_q     <= start;
      out_vld_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) item_q <= '{opcode: opcode_i, is_double: is_double_i,
                           a: operand_a_i, b: operand_b_i};
    if (vld_q) res_q <= res_d;
  end

  fmr_datapath u_dp (
    .item_i   (item_q),
    .result_o (res_d)
  );

  assign done_o        = out_vld_q;
  assign result_bits_o = res_q;

endmodule
`default_nettype wire
